>>> rtl/bbc_pkg.sv
package bbc_pkg;

    localparam int ENTRIES = 64;
    localparam int SECTORS_PER_BLOCK = 8;
    localparam int SECTOR_W = 48;
    localparam int DEV_W = 8;
    localparam int HANDLE_W = 6;
    localparam int OFFSET_W = 4;
    localparam int LIMIT_W = 7;

    // Bit positions inside the per-entry flag word.
    localparam int FL_VALID = 0;
    localparam int FL_DIRTY = 1;
    localparam int FL_INUSE = 2;

    typedef enum logic [2:0] {
        FN_GET     = 3'd0,
        FN_RELEASE = 3'd1,
        FN_WSTART  = 3'd2,
        FN_WDONE   = 3'd3,
        FN_RDONE   = 3'd4,
        FN_ADVANCE = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        ST_GRANTED = 2'd0,
        ST_BUSY    = 2'd1,
        ST_NOFREE  = 2'd2,
        ST_DONE    = 2'd3
    } status_t;

endpackage

>>> rtl/block_buffer_cache_lru_unit.sv
// Buffer cache tag and recency manager. One word is taken at a time; the
// block stalls its input until the result word has left, and also while a
// limit write is offered. A get walks the allocated entries of the tag
// memory one entry per cycle, walks them again to pick the least recent
// free victim when the limit is reached and the tag missed, and a granted
// get, unless no entry was allocated before, walks once more to update
// recency ranks before a commit state. The walks are serial because the
// entry memories have one read address each. Any other operation
// registers its result in state S_OTHER from the entry read at
// acceptance. Only entries below the allocation count are ever used, so
// no clearing pass is needed after reset.
module block_buffer_cache_lru_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bbc_pkg::LIMIT_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    func,
    input  logic [bbc_pkg::DEV_W-1:0]     dev,
    input  logic [bbc_pkg::SECTOR_W-1:0]  sector,
    input  logic [bbc_pkg::HANDLE_W-1:0]  entry,
    input  logic                          io_error,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [bbc_pkg::HANDLE_W-1:0]  entry_out,
    output logic                          hit,
    output logic                          data_valid,
    output logic [bbc_pkg::OFFSET_W-1:0]  offset,
    output logic                          wake
);
    import bbc_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int SPB_W = (SECTORS_PER_BLOCK > 1) ? $clog2(SECTORS_PER_BLOCK) : 1;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_TAG    = 7'b0000010,
        S_VICT   = 7'b0000100,
        S_RANK   = 7'b0001000,
        S_COMMIT = 7'b0010000,
        S_OTHER  = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t state_reg;

    // Entry memories (written/read in clocked blocks).
    logic [DEV_W-1:0]    mem_dev   [ENTRIES];
    logic [SECTOR_W-1:0] mem_base  [ENTRIES];
    logic [IW-1:0]       mem_rank  [ENTRIES];
    logic [2:0]          mem_flags [ENTRIES];
    logic [OFFSET_W-1:0] mem_offs  [ENTRIES];
    logic [DEV_W-1:0]    rd_dev_reg;
    logic [SECTOR_W-1:0] rd_base_reg;
    logic [IW-1:0]       rd_rank_reg;
    logic [2:0]          rd_flags_reg;
    logic [OFFSET_W-1:0] rd_offs_reg;

    logic [CW-1:0]       count_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    // Captured request.
    logic [2:0]          func_reg;
    logic [DEV_W-1:0]    dev_reg;
    logic [SECTOR_W-1:0] base_reg;
    logic [OFFSET_W-1:0] off_reg;
    logic [HANDLE_W-1:0] hnd_reg;
    logic                err_reg;

    // Scan state.
    logic [CW-1:0]       idx_reg;     // address issued
    logic [CW-1:0]       cmp_reg;     // address whose data is in rd_*_reg
    logic                cmp_v_reg;
    logic [IW-1:0]       e_reg;
    logic                found_reg;
    logic                evalid_reg;
    logic                fresh_reg;
    logic                any_reg;
    logic [IW-1:0]       best_reg;
    logic [IW-1:0]       erank_reg;
    logic [IW-1:0]       wr_rank_idx;
    logic                rank_we;
    logic [IW-1:0]       rank_wdata;
    logic                tag_we;
    logic                ent_we;
    logic [IW-1:0]       ent_waddr;
    logic [2:0]          ent_wflags;
    logic [OFFSET_W-1:0] ent_woff;

    // Next flags, offset and wake of a non-get operation.
    logic                oth_ok;
    logic [2:0]          oth_flags;
    logic [OFFSET_W-1:0] oth_off;
    logic                oth_wake;

    logic [1:0]          o_status_reg;
    logic [HANDLE_W-1:0] o_entry_reg;
    logic                o_hit_reg, o_dv_reg, o_wake_reg, o_valid_reg;
    logic [OFFSET_W-1:0] o_off_reg;

    logic [CW-1:0]       limit_eff;
    logic                in_acc;
    logic [SPB_W-1:0]    sec_off;
    logic [IW-1:0]       idx_a, cmp_a, rd_addr;
    logic                scan_end;

    assign in_stall  = (state_reg != S_IDLE) || cfg_valid;
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = o_valid_reg;
    assign status = o_status_reg;
    assign entry_out = o_entry_reg;
    assign hit = o_hit_reg;
    assign data_valid = o_dv_reg;
    assign offset = o_off_reg;
    assign wake = o_wake_reg;

    assign limit_eff = (32'(limit_reg) < ENTRIES) ? CW'(limit_reg) : CW'(ENTRIES);
    assign sec_off = (SECTORS_PER_BLOCK > 1) ? SPB_W'(sector % SECTORS_PER_BLOCK) : '0;
    assign idx_a = idx_reg[IW-1:0];
    assign cmp_a = cmp_reg[IW-1:0];
    assign scan_end = (idx_reg >= count_reg);

    // While idle the addressed handle is read so a non-get finds its entry ready.
    assign rd_addr = (state_reg == S_IDLE) ? entry[IW-1:0] : idx_a;

    // Memory ports: one read address, one write address per memory.
    always_ff @(posedge clk)
    begin
        rd_dev_reg   <= mem_dev[rd_addr];
        rd_base_reg  <= mem_base[rd_addr];
        rd_rank_reg  <= mem_rank[rd_addr];
        rd_flags_reg <= mem_flags[rd_addr];
        rd_offs_reg  <= mem_offs[rd_addr];
        if (tag_we)
        begin
            mem_dev[e_reg]  <= dev_reg;
            mem_base[e_reg] <= base_reg;
        end
        if (rank_we)
            mem_rank[wr_rank_idx] <= rank_wdata;
        if (ent_we)
        begin
            mem_flags[ent_waddr] <= ent_wflags;
            mem_offs[ent_waddr]  <= ent_woff;
        end
    end

    // Effect of a non-get operation on the entry read at acceptance.
    always_comb
    begin
        oth_ok = (func_reg <= 3'(FN_ADVANCE)) && (CW'(hnd_reg) < count_reg);
        oth_flags = rd_flags_reg;
        oth_off = rd_offs_reg;
        oth_wake = 1'b0;
        case (func_t'(func_reg))
            FN_RELEASE:
            begin
                oth_flags[FL_INUSE] = 1'b0;
                oth_wake = !rd_flags_reg[FL_DIRTY];
            end
            FN_WSTART:
            begin
                oth_flags[FL_DIRTY] = 1'b1;
                oth_flags[FL_VALID] = 1'b0;
            end
            FN_WDONE:
            begin
                if (!err_reg)
                    oth_flags[FL_VALID] = 1'b1;
                oth_flags[FL_DIRTY] = 1'b0;
                oth_wake = !rd_flags_reg[FL_INUSE];
            end
            FN_RDONE:
            begin
                if (!err_reg)
                    oth_flags[FL_VALID] = 1'b1;
                oth_wake = 1'b1;
            end
            FN_ADVANCE:
            begin
                if (32'(rd_offs_reg) < SECTORS_PER_BLOCK)
                    oth_off = rd_offs_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // Rank update pass and entry writes.
    always_comb
    begin
        rank_we = 1'b0;
        wr_rank_idx = cmp_a;
        rank_wdata = rd_rank_reg;
        if (state_reg == S_RANK && cmp_v_reg)
        begin
            if (cmp_a == e_reg)
            begin
                rank_we = 1'b1;
                rank_wdata = '0;
            end
            else if (fresh_reg || rd_rank_reg < erank_reg)
            begin
                rank_we = 1'b1;
                rank_wdata = rd_rank_reg + 1'b1;
            end
        end
        else if (state_reg == S_COMMIT && fresh_reg)
        begin
            rank_we = 1'b1;
            wr_rank_idx = e_reg;
            rank_wdata = '0;
        end
        tag_we = (state_reg == S_COMMIT) && !found_reg;

        ent_we = 1'b0;
        ent_waddr = e_reg;
        ent_wflags = oth_flags;
        ent_woff = off_reg;
        if (state_reg == S_COMMIT)
        begin
            // A granted entry is in use; a hit keeps its valid bit.
            ent_we = 1'b1;
            ent_wflags = '0;
            ent_wflags[FL_INUSE] = 1'b1;
            ent_wflags[FL_VALID] = found_reg && evalid_reg;
        end
        else if (state_reg == S_OTHER && oth_ok)
        begin
            ent_we = 1'b1;
            ent_waddr = hnd_reg[IW-1:0];
            ent_woff = oth_off;
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            limit_reg <= LIMIT_W'(64);
            o_valid_reg <= 1'b0;
            o_status_reg <= '0;
            o_entry_reg <= '0;
            o_hit_reg <= 1'b0;
            o_dv_reg <= 1'b0;
            o_off_reg <= '0;
            o_wake_reg <= 1'b0;
            cmp_v_reg <= 1'b0;
            idx_reg <= '0;
            cmp_reg <= '0;
            found_reg <= 1'b0;
            evalid_reg <= 1'b0;
            fresh_reg <= 1'b0;
            any_reg <= 1'b0;
            e_reg <= '0;
            best_reg <= '0;
            erank_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                limit_reg <= cfg_data;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        state_reg <= (func == FN_GET) ? S_TAG : S_OTHER;
                        idx_reg <= '0;
                        cmp_v_reg <= 1'b0;
                        found_reg <= 1'b0;
                        fresh_reg <= 1'b0;
                        any_reg <= 1'b0;
                        e_reg <= '0;
                        best_reg <= '0;
                    end
                end
                S_TAG:
                begin
                    // Compare one entry per cycle.
                    if (cmp_v_reg && rd_dev_reg == dev_reg && rd_base_reg == base_reg)
                    begin
                        found_reg <= 1'b1;
                        e_reg <= cmp_a;
                        erank_reg <= rd_rank_reg;
                        evalid_reg <= rd_flags_reg[FL_VALID];
                        idx_reg <= '0;
                        cmp_v_reg <= 1'b0;
                        if (rd_flags_reg[FL_INUSE] || rd_flags_reg[FL_DIRTY])
                        begin
                            o_status_reg <= ST_BUSY;
                            o_entry_reg <= HANDLE_W'(cmp_a);
                            o_hit_reg <= 1'b1;
                            o_dv_reg <= 1'b0;
                            o_off_reg <= '0;
                            o_wake_reg <= 1'b0;
                            o_valid_reg <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else
                            state_reg <= S_RANK;
                    end
                    else if (!scan_end)
                    begin
                        cmp_reg <= idx_reg;
                        cmp_v_reg <= 1'b1;
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else if (count_reg < limit_eff)
                    begin
                        // Fresh allocation.
                        e_reg <= count_reg[IW-1:0];
                        fresh_reg <= 1'b1;
                        idx_reg <= '0;
                        cmp_v_reg <= 1'b0;
                        state_reg <= (count_reg == '0) ? S_COMMIT : S_RANK;
                    end
                    else
                    begin
                        state_reg <= S_VICT;
                        idx_reg <= '0;
                        cmp_v_reg <= 1'b0;
                    end
                end
                S_VICT:
                begin
                    if (cmp_v_reg && !rd_flags_reg[FL_INUSE] && !rd_flags_reg[FL_DIRTY]
                        && (!any_reg || rd_rank_reg > best_reg))
                    begin
                        any_reg <= 1'b1;
                        best_reg <= rd_rank_reg;
                        e_reg <= cmp_a;
                    end
                    if (!scan_end)
                    begin
                        cmp_reg <= idx_reg;
                        cmp_v_reg <= 1'b1;
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else if (cmp_v_reg)
                        cmp_v_reg <= 1'b0;
                    else if (!any_reg)
                    begin
                        o_status_reg <= ST_NOFREE;
                        o_entry_reg <= '0;
                        o_hit_reg <= 1'b0;
                        o_dv_reg <= 1'b0;
                        o_off_reg <= '0;
                        o_wake_reg <= 1'b0;
                        o_valid_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        erank_reg <= best_reg;
                        state_reg <= S_RANK;
                        idx_reg <= '0;
                    end
                end
                S_RANK:
                begin
                    if (!scan_end)
                    begin
                        cmp_reg <= idx_reg;
                        cmp_v_reg <= 1'b1;
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else if (cmp_v_reg)
                        cmp_v_reg <= 1'b0;
                    else
                        state_reg <= S_COMMIT;
                end
                S_COMMIT:
                begin
                    if (fresh_reg)
                        count_reg <= count_reg + 1'b1;
                    o_status_reg <= ST_GRANTED;
                    o_entry_reg <= HANDLE_W'(e_reg);
                    o_hit_reg <= found_reg;
                    o_dv_reg <= found_reg && evalid_reg;
                    o_off_reg <= off_reg;
                    o_wake_reg <= 1'b0;
                    o_valid_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OTHER:
                begin
                    // Unallocated handles and unknown codes only echo the handle.
                    o_status_reg <= ST_DONE;
                    o_entry_reg <= hnd_reg;
                    o_hit_reg <= 1'b0;
                    o_dv_reg <= oth_ok && oth_flags[FL_VALID];
                    o_off_reg <= oth_ok ? oth_off : '0;
                    o_wake_reg <= oth_ok && oth_wake;
                    o_valid_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        o_valid_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            func_reg <= func;
            dev_reg <= dev;
            base_reg <= sector - SECTOR_W'(sec_off);
            off_reg <= OFFSET_W'(sec_off);
            hnd_reg <= entry;
            err_reg <= io_error;
        end
    end

    // The allocation count never passes the entry count.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(ENTRIES))
        else $error("allocation count beyond entry count");

    // A result only appears after the sequencer finished an item.
    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(o_valid_reg) |-> state_reg == S_OUT)
        else $error("result raised outside output state");

    // A granted entry always lies below the allocation count.
    a_grant_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(o_valid_reg) && o_status_reg == ST_GRANTED |->
            CW'(o_entry_reg) < count_reg)
        else $error("granted entry not allocated");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import bbc_pkg::*;

    localparam int NUM_ENTRIES = 64;
    localparam int BLOCK_SECTORS = 8;
    localparam int IDLE_LIMIT = 8000;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] entry_out;
        logic       hit;
        logic       data_valid;
        logic [3:0] offset;
        logic       wake;
    } cache_resp_t;

    typedef struct {
        logic [2:0]  func;
        logic [7:0]  dev;
        logic [47:0] sector;
        logic [5:0]  entry;
        logic        io_error;
        bit          typed;
        cache_resp_t resp;
    } cache_req_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  func;
    logic [7:0]  dev;
    logic [47:0] sector;
    logic [5:0]  entry;
    logic        io_error;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [5:0]  entry_out;
    logic        hit;
    logic        data_valid;
    logic [3:0]  offset;
    logic        wake;

    // Shadow copy of the cache bookkeeping.
    logic [7:0]  sh_dev [NUM_ENTRIES];
    logic [47:0] sh_base [NUM_ENTRIES];
    logic [2:0]  sh_flags [NUM_ENTRIES];
    logic [3:0]  sh_off [NUM_ENTRIES];
    int unsigned sh_rank [NUM_ENTRIES];
    int unsigned sh_used;
    int unsigned sh_limit;

    cache_resp_t pending_resp[$];
    cache_req_t  directed_rows[$];
    int unsigned mismatches;
    int unsigned words_in;
    int unsigned words_out;
    int unsigned idle_cycles;
    int unsigned n_gets;
    int unsigned n_hits;
    int unsigned n_busy;
    int unsigned n_nofree;
    int unsigned n_evict;
    bit          stall_test_done;

    block_buffer_cache_lru_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .dev(dev), .sector(sector), .entry(entry), .io_error(io_error),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .entry_out(entry_out), .hit(hit),
        .data_valid(data_valid), .offset(offset), .wake(wake)
    );

    always #4 clk = ~clk;

    // Move entry e to the front of the recency order.
    function automatic void touch_entry(input int unsigned e, input bit listed);
        for (int unsigned i = 0; i < sh_used; i++)
        begin
            if (i != e && (!listed || sh_rank[i] < sh_rank[e]))
                sh_rank[i]++;
        end
        sh_rank[e] = 0;
    endfunction

    function automatic cache_resp_t make_resp(input status_t st, input int unsigned e,
                                              input bit h, input bit dv,
                                              input int unsigned off, input bit wk);
        cache_resp_t r;
        r.status = st;
        r.entry_out = e[5:0];
        r.hit = h;
        r.data_valid = dv;
        r.offset = off[3:0];
        r.wake = wk;
        return r;
    endfunction

    // Apply one word to the shadow state and return the response it produces.
    function automatic cache_resp_t cache_update(input cache_req_t q);
        int unsigned lim;
        int unsigned off;
        int unsigned e;
        int unsigned best;
        logic [47:0] base;
        bit found;
        bit any;
        bit wk;
        lim = (sh_limit < NUM_ENTRIES) ? sh_limit : NUM_ENTRIES;
        e = q.entry;
        wk = 0;
        if (q.func == FN_GET)
        begin
            n_gets++;
            off = 32'(q.sector % BLOCK_SECTORS);
            base = q.sector - 48'(off);
            found = 0;
            for (int unsigned i = 0; i < sh_used && !found; i++)
            begin
                if (sh_dev[i] == q.dev && sh_base[i] == base)
                begin
                    e = i;
                    found = 1;
                end
            end
            if (found)
            begin
                n_hits++;
                if (sh_flags[e][FL_INUSE] || sh_flags[e][FL_DIRTY])
                begin
                    n_busy++;
                    return make_resp(ST_BUSY, e, 1, 0, 0, 0);
                end
                touch_entry(e, 1);
            end
            else
            begin
                if (sh_used < lim)
                begin
                    e = sh_used;
                    sh_used++;
                    touch_entry(e, 0);
                end
                else
                begin
                    any = 0;
                    best = 0;
                    for (int unsigned i = 0; i < sh_used; i++)
                    begin
                        if (!(sh_flags[i][FL_INUSE] || sh_flags[i][FL_DIRTY])
                            && (!any || sh_rank[i] > best))
                        begin
                            any = 1;
                            best = sh_rank[i];
                            e = i;
                        end
                    end
                    if (!any)
                    begin
                        n_nofree++;
                        return make_resp(ST_NOFREE, 0, 0, 0, 0, 0);
                    end
                    n_evict++;
                    touch_entry(e, 1);
                end
                sh_flags[e] = 3'b000;
                sh_dev[e] = q.dev;
                sh_base[e] = base;
            end
            sh_off[e] = 4'(off);
            sh_flags[e][FL_INUSE] = 1'b1;
            return make_resp(ST_GRANTED, e, found, sh_flags[e][FL_VALID], off, 0);
        end
        if (q.func > FN_ADVANCE || e >= sh_used)
            return make_resp(ST_DONE, e, 0, 0, 0, 0);
        case (q.func)
            FN_RELEASE:
            begin
                sh_flags[e][FL_INUSE] = 1'b0;
                wk = !sh_flags[e][FL_DIRTY];
            end
            FN_WSTART:
            begin
                sh_flags[e][FL_DIRTY] = 1'b1;
                sh_flags[e][FL_VALID] = 1'b0;
            end
            FN_WDONE:
            begin
                if (!q.io_error)
                    sh_flags[e][FL_VALID] = 1'b1;
                sh_flags[e][FL_DIRTY] = 1'b0;
                wk = !sh_flags[e][FL_INUSE];
            end
            FN_RDONE:
            begin
                if (!q.io_error)
                    sh_flags[e][FL_VALID] = 1'b1;
                wk = 1;
            end
            default:
            begin
                if (sh_off[e] < BLOCK_SECTORS)
                    sh_off[e]++;
            end
        endcase
        return make_resp(ST_DONE, e, 0, sh_flags[e][FL_VALID], sh_off[e], wk);
    endfunction

    function automatic cache_req_t mk_row(input logic [2:0] f, input logic [7:0] d,
                                          input logic [47:0] s, input logic [5:0] e,
                                          input logic err);
        cache_req_t q;
        q.func = f;
        q.dev = d;
        q.sector = s;
        q.entry = e;
        q.io_error = err;
        q.typed = 0;
        q.resp = '0;
        return q;
    endfunction

    function automatic cache_req_t mk_typed(input cache_req_t q, input cache_resp_t r);
        q.typed = 1;
        q.resp = r;
        return q;
    endfunction

    // Random word: mostly a small working set of blocks so hits and evictions occur.
    function automatic cache_req_t random_req();
        cache_req_t q;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        q = mk_row(FN_GET, 0, 0, 0, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 9) < 8)
            q.dev = 8'($urandom_range(0, 3));
        else
            q.dev = 8'($urandom);
        if ($urandom_range(0, 9) < 8)
            q.sector = 48'($urandom_range(0, 20) * BLOCK_SECTORS + $urandom_range(0, 7));
        else
            q.sector = 48'({$urandom, $urandom});
        if ($urandom_range(0, 9) < 9 && sh_used > 0)
            q.entry = 6'($urandom_range(0, sh_used - 1));
        else
            q.entry = 6'($urandom);
        if (pick < 40)
            q.func = FN_GET;
        else if (pick < 60)
            q.func = FN_RELEASE;
        else if (pick < 68)
            q.func = FN_WSTART;
        else if (pick < 78)
            q.func = FN_WDONE;
        else if (pick < 88)
            q.func = FN_RDONE;
        else if (pick < 96)
            q.func = FN_ADVANCE;
        else
            q.func = 3'($urandom_range(6, 7));
        return q;
    endfunction

    function automatic int unsigned random_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        else if (pick < 95)
            return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    // Offer one word and hold it until the block takes it.
    task automatic send_word(input cache_req_t q);
        in_valid <= 1'b1;
        func <= q.func;
        dev <= q.dev;
        sector <= q.sector;
        entry <= q.entry;
        io_error <= q.io_error;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_gap(input int unsigned n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_resp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input int unsigned v);
        cfg_valid <= 1'b1;
        cfg_data <= v[6:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Accepted words feed the shadow model; accepted results are checked.
    always @(posedge clk)
    begin
        cache_req_t  q;
        cache_resp_t exp_r;
        cache_resp_t got;
        cache_resp_t pred;
        if (rst_n && cfg_valid && cfg_ready)
        begin
            sh_limit = cfg_data;
            idle_cycles = 0;
        end
        if (rst_n && in_valid && !in_stall)
        begin
            q = directed_rows.size() ? directed_rows[0] : mk_row(func, dev, sector, entry,
                                                                 io_error);
            q.func = func;
            q.dev = dev;
            q.sector = sector;
            q.entry = entry;
            q.io_error = io_error;
            if (directed_rows.size())
                void'(directed_rows.pop_front());
            pred = cache_update(q);
            pending_resp.push_back(q.typed ? q.resp : pred);
            words_in++;
            idle_cycles = 0;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            got = {status, entry_out, hit, data_valid, offset, wake};
            words_out++;
            idle_cycles = 0;
            if (pending_resp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result word with nothing pending: %p", got);
            end
            else
            begin
                exp_r = pending_resp.pop_front();
                if (got !== exp_r)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: word %0d expected %p got %p", words_out, exp_r, got);
                end
            end
        end
    end

    // Watchdog on cycles in which nothing moves.
    always @(posedge clk)
    begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: random stall stretches, one long hold-off part way through.
    initial
    begin
        int unsigned n;
        out_stall = 1'b0;
        stall_test_done = 0;
        @(posedge rst_n);
        forever
        begin
            if (!stall_test_done && words_in >= 600)
            begin
                stall_test_done = 1;
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
            out_stall <= 1'b0;
            repeat (n) @(posedge clk);
            n = random_gap();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
        end
    end

    initial
    begin
        int unsigned phase_limits [5];
        cache_req_t q;
        cache_req_t rows[$];
        phase_limits = '{8, 1, 64, 2, 37};
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        func = '0;
        dev = '0;
        sector = '0;
        entry = '0;
        io_error = 1'b0;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            sh_flags[i] = '0;
            sh_off[i] = '0;
            sh_rank[i] = 0;
            sh_dev[i] = '0;
            sh_base[i] = '0;
        end
        sh_used = 0;
        sh_limit = 64;
        mismatches = 0;
        words_in = 0;
        words_out = 0;
        idle_cycles = 0;
        n_gets = 0;
        n_hits = 0;
        n_busy = 0;
        n_nofree = 0;
        n_evict = 0;

        // Directed words; responses readable at a glance are typed in.
        directed_rows.push_back(mk_typed(mk_row(FN_RELEASE, 0, 0, 0, 0),
                                         make_resp(ST_DONE, 0, 0, 0, 0, 0)));
        directed_rows.push_back(mk_typed(mk_row(3'd6, 8'hff, 48'hffff_ffff_ffff, 63, 1),
                                         make_resp(ST_DONE, 63, 0, 0, 0, 0)));
        directed_rows.push_back(mk_typed(mk_row(3'd7, 0, 0, 5, 0),
                                         make_resp(ST_DONE, 5, 0, 0, 0, 0)));
        directed_rows.push_back(mk_typed(mk_row(FN_GET, 0, 0, 0, 0),
                                         make_resp(ST_GRANTED, 0, 0, 0, 0, 0)));
        directed_rows.push_back(mk_typed(mk_row(FN_GET, 8'hff, 48'hffff_ffff_ffff, 0, 0),
                                         make_resp(ST_GRANTED, 1, 0, 0, 7, 0)));
        directed_rows.push_back(mk_typed(mk_row(FN_GET, 0, 3, 0, 0),
                                         make_resp(ST_BUSY, 0, 1, 0, 0, 0)));
        directed_rows.push_back(mk_row(FN_RDONE, 0, 0, 0, 1));
        directed_rows.push_back(mk_row(FN_RDONE, 0, 0, 1, 0));
        directed_rows.push_back(mk_row(FN_ADVANCE, 0, 0, 1, 0));
        directed_rows.push_back(mk_row(FN_ADVANCE, 0, 0, 1, 0));
        directed_rows.push_back(mk_row(FN_RELEASE, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(FN_RELEASE, 0, 0, 1, 0));
        directed_rows.push_back(mk_row(FN_GET, 0, 5, 0, 0));
        directed_rows.push_back(mk_row(FN_WSTART, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(FN_WDONE, 0, 0, 0, 1));
        directed_rows.push_back(mk_row(FN_WDONE, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(FN_RELEASE, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(FN_WSTART, 0, 0, 1, 0));
        directed_rows.push_back(mk_row(FN_GET, 8'hff, 48'hffff_ffff_fff8, 0, 0));
        directed_rows.push_back(mk_row(FN_RELEASE, 0, 0, 1, 0));
        directed_rows.push_back(mk_row(FN_WDONE, 0, 0, 1, 0));
        directed_rows.push_back(mk_typed(mk_row(FN_ADVANCE, 0, 0, 62, 1),
                                         make_resp(ST_DONE, 62, 0, 0, 0, 0)));
        rows = directed_rows;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; the monitor pairs each word with its row.
        for (int i = 0; i < rows.size(); i++)
        begin
            q = rows[i];
            send_word(q);
            send_gap(random_gap());
        end

        // Random phases, each under its own allocation limit.
        foreach (phase_limits[p])
        begin
            drain();
            write_limit(phase_limits[p]);
            for (int i = 0; i < 390; i++)
            begin
                send_word(random_req());
                send_gap(random_gap());
            end
        end

        drain();
        repeat (200) @(posedge clk);
        $display("Covered %0d words in, %0d results out over limits 64, 8, 1, 64, 2, 37.",
                 words_in, words_out);
        $display("Gets %0d: hits %0d, busy %0d, evictions %0d, no free entry %0d.",
                 n_gets, n_hits, n_busy, n_evict, n_nofree);
        if (mismatches == 0 && pending_resp.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/bbc_pkg.sv
rtl/block_buffer_cache_lru_unit.sv
verif/tb_top.sv
